// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL files; the scheduler core uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SSTF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define SSTF_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`endif

// ===== rtl/sstf_pkg.sv =====
package sstf_pkg;

    // Fixed field widths of the channels
    localparam int TAG_W = 8;
    localparam int CYL_W = 12;
    localparam int SUM_W = 18;

    // Saturation value of the running head movement
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // One served request as presented on the result channel
    typedef struct packed {
        logic [TAG_W-1:0] served_tag;
        logic [CYL_W-1:0] served_cylinder;
        logic [CYL_W-1:0] seek_distance;
        logic [SUM_W-1:0] total_movement;
        logic             final_result;
    } t_result;

endpackage

// ===== rtl/sstf_req_if.sv =====
interface sstf_req_if;
    logic                        valid;
    logic                        ready;
    logic [sstf_pkg::TAG_W-1:0]  request_tag;
    logic [sstf_pkg::CYL_W-1:0]  request_cylinder;
    logic                        last_request;

    modport source (output valid, request_tag, request_cylinder, last_request, input ready);
    modport sink   (input valid, request_tag, request_cylinder, last_request, output ready);
endinterface

// ===== rtl/sstf_res_if.sv =====
interface sstf_res_if;
    logic                        valid;
    logic                        ready;
    logic [sstf_pkg::TAG_W-1:0]  served_tag;
    logic [sstf_pkg::CYL_W-1:0]  served_cylinder;
    logic [sstf_pkg::CYL_W-1:0]  seek_distance;
    logic [sstf_pkg::SUM_W-1:0]  total_movement;
    logic                        final_result;

    modport source (output valid, served_tag, served_cylinder, seek_distance,
                    total_movement, final_result, input ready);
    modport sink   (input valid, served_tag, served_cylinder, seek_distance,
                    total_movement, final_result, output ready);
endinterface

// ===== rtl/sstf_cfg_if.sv =====
interface sstf_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [sstf_pkg::CYL_W-1:0]  start_head;

    modport source (output valid, start_head, input ready);
    modport sink   (input valid, start_head, output ready);
endinterface

// ===== rtl/sstf_ram.sv =====
module sstf_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/sstf_disk_scheduler_core.sv =====
// Shortest-seek-time-first disk scheduler.
// i_req loads one request (tag, cylinder) per item into a request store of
// MAX_REQUESTS entries; items beyond that are dropped. An item with
// last_request set (stored or dropped) starts scheduling of the batch.
// o_res then gives one item per stored request in service order: the nearest
// unserved cylinder to the head, ties to the earliest loaded, with its seek
// distance and the saturating running movement; final_result marks the last.
// i_cfg writes start_head, the head cylinder at the start of every batch.
// Loading accepts one item per cycle. Each selection reads the N stored entries
// one per cycle from the read port of the store RAM, then emits its pick.
// i_req is ready only while no batch is being scheduled; the last result may
// still wait in the output register while the next batch loads.
// A stalled o_res holds the result; scanning goes on, but the next emit waits.
// Reset (synchronous, active low) empties the batch, clears the served
// flags, head, movement sum and start_head; no clearing pass is needed.
`include "assert_macros.svh"

module sstf_disk_scheduler_core #(
    parameter int MAX_REQUESTS  = 8,
    parameter int CYLINDER_BITS = 12
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sstf_req_if.sink   i_req,
    sstf_res_if.source o_res,
    sstf_cfg_if.sink   i_cfg
);

    localparam int CW    = (CYLINDER_BITS < sstf_pkg::CYL_W) ? CYLINDER_BITS
                                                             : sstf_pkg::CYL_W;
    localparam int AW    = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CNTW  = $clog2(MAX_REQUESTS + 1);
    localparam int DW    = sstf_pkg::TAG_W + CW;
    localparam int SUMW1 = sstf_pkg::SUM_W + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]                  r_state, n_state;
    logic [CNTW-1:0]             r_count, n_count;
    logic [MAX_REQUESTS-1:0]     r_served, n_served;
    logic [CW-1:0]               r_head, n_head;
    logic [sstf_pkg::SUM_W-1:0]  r_sum, n_sum;
    logic [CNTW-1:0]             r_served_cnt, n_served_cnt;
    logic [CNTW-1:0]             r_rd_idx, n_rd_idx;
    logic                        r_cmp_valid, n_cmp_valid;
    logic [CNTW-1:0]             r_cmp_idx, n_cmp_idx;
    logic                        r_found, n_found;
    logic [CW-1:0]               r_best, n_best;
    logic [AW-1:0]               r_pick_idx, n_pick_idx;
    logic [sstf_pkg::TAG_W-1:0]  r_pick_tag, n_pick_tag;
    logic [CW-1:0]               r_pick_cyl, n_pick_cyl;
    logic [CW-1:0]               r_start_head;
    logic                        r_out_valid, n_out_valid;
    sstf_pkg::t_result           r_out, n_out;

    logic                        in_fire;
    logic                        has_room;
    logic                        ram_we;
    logic [DW-1:0]               ram_wdata;
    logic [DW-1:0]               ram_rdata;
    logic [sstf_pkg::TAG_W-1:0]  rd_tag;
    logic [CW-1:0]               rd_cyl;
    logic [CW-1:0]               rd_dist;
    logic                        take;
    logic                        emit_ok;
    logic                        is_final;
    logic [SUMW1-1:0]            sum_add;
    logic [sstf_pkg::SUM_W-1:0]  sum_sat;

    // Handshakes
    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_fire     = i_req.valid && i_req.ready;
    assign has_room    = (r_count < CNTW'(MAX_REQUESTS));

    // Request store
    assign ram_we    = in_fire && has_room;
    assign ram_wdata = {i_req.request_tag, i_req.request_cylinder[CW-1:0]};

    sstf_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_REQUESTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Distance of the entry read back against the current head
    assign rd_tag  = ram_rdata[DW-1 -: sstf_pkg::TAG_W];
    assign rd_cyl  = ram_rdata[CW-1:0];
    assign rd_dist = (rd_cyl > r_head) ? (rd_cyl - r_head) : (r_head - rd_cyl);
    assign take    = r_cmp_valid && !r_served[r_cmp_idx[AW-1:0]]
                     && (!r_found || (rd_dist < r_best));

    // Emit step: saturating movement and last-of-batch flag
    assign emit_ok  = !r_out_valid || o_res.ready;
    assign is_final = ((r_served_cnt + CNTW'(1)) == r_count);
    assign sum_add  = {1'b0, r_sum} + SUMW1'(r_best);
    assign sum_sat  = sum_add[sstf_pkg::SUM_W] ? sstf_pkg::SUM_MAX
                                               : sum_add[sstf_pkg::SUM_W-1:0];

    // Next-state logic
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_served     = r_served;
        n_head       = r_head;
        n_sum        = r_sum;
        n_served_cnt = r_served_cnt;
        n_rd_idx     = r_rd_idx;
        n_cmp_valid  = 1'b0;
        n_cmp_idx    = r_cmp_idx;
        n_found      = r_found;
        n_best       = r_best;
        n_pick_idx   = r_pick_idx;
        n_pick_tag   = r_pick_tag;
        n_pick_cyl   = r_pick_cyl;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out        = r_out;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (has_room) begin
                        n_count = r_count + CNTW'(1);
                    end
                    if (i_req.last_request) begin
                        n_state      = S_SCAN;
                        n_head       = r_start_head;
                        n_sum        = '0;
                        n_served_cnt = '0;
                        n_rd_idx     = '0;
                        n_found      = 1'b0;
                    end
                end
            end
            S_SCAN: begin
                // issue one read per cycle, compare it in the next cycle
                if (r_rd_idx < r_count) begin
                    n_rd_idx    = r_rd_idx + CNTW'(1);
                    n_cmp_valid = 1'b1;
                    n_cmp_idx   = r_rd_idx;
                end
                if (take) begin
                    n_found    = 1'b1;
                    n_best     = rd_dist;
                    n_pick_idx = r_cmp_idx[AW-1:0];
                    n_pick_tag = rd_tag;
                    n_pick_cyl = rd_cyl;
                end
                if (r_cmp_valid && (r_cmp_idx == (r_count - CNTW'(1)))) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (emit_ok) begin
                    n_out_valid                 = 1'b1;
                    n_out.served_tag            = r_pick_tag;
                    n_out.served_cylinder       = sstf_pkg::CYL_W'(r_pick_cyl);
                    n_out.seek_distance         = sstf_pkg::CYL_W'(r_best);
                    n_out.total_movement        = sum_sat;
                    n_out.final_result          = is_final;
                    n_served[r_pick_idx]        = 1'b1;
                    n_head                      = r_pick_cyl;
                    n_sum                       = sum_sat;
                    n_served_cnt                = r_served_cnt + CNTW'(1);
                    n_rd_idx                    = '0;
                    n_found                     = 1'b0;
                    if (is_final) begin
                        n_state  = S_IDLE;
                        n_count  = '0;
                        n_served = '0;
                        n_sum    = '0;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_served     <= '0;
            r_head       <= '0;
            r_sum        <= '0;
            r_served_cnt <= '0;
            r_rd_idx     <= '0;
            r_cmp_valid  <= 1'b0;
            r_found      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_served     <= n_served;
            r_head       <= n_head;
            r_sum        <= n_sum;
            r_served_cnt <= n_served_cnt;
            r_rd_idx     <= n_rd_idx;
            r_cmp_valid  <= n_cmp_valid;
            r_found      <= n_found;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmp_idx  <= n_cmp_idx;
        r_best     <= n_best;
        r_pick_idx <= n_pick_idx;
        r_pick_tag <= n_pick_tag;
        r_pick_cyl <= n_pick_cyl;
        r_out      <= n_out;
    end

    // Start head register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_head <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_start_head <= i_cfg.start_head[CW-1:0];
        end
    end

    // Result channel
    assign o_res.valid           = r_out_valid;
    assign o_res.served_tag      = r_out.served_tag;
    assign o_res.served_cylinder = r_out.served_cylinder;
    assign o_res.seek_distance   = r_out.seek_distance;
    assign o_res.total_movement  = r_out.total_movement;
    assign o_res.final_result    = r_out.final_result;

    // Checks
    `SSTF_ASSERT(a_served_below_count, i_clk, i_rst_n,
        (r_state != S_IDLE) |-> (r_served_cnt < r_count), "served count reached batch size")
    `SSTF_ASSERT(a_pick_unserved, i_clk, i_rst_n,
        (r_state == S_EMIT) |-> (r_found && !r_served[r_pick_idx]), "emit without valid pick")
    `SSTF_ASSERT(a_cmp_in_range, i_clk, i_rst_n,
        r_cmp_valid |-> ((r_cmp_idx < r_count) && (r_state == S_SCAN)), "compare outside batch")
    `SSTF_NEVER(a_flags_clear_on_load, i_clk, i_rst_n,
        in_fire && (r_served != '0), "served flags left over between batches")

endmodule
